### hdl/bfl_pkg.sv
// Shared types, constants and the reciprocal table for the line box filter.
package bfl_pkg;

    localparam int MAX_KERNEL  = 15;
    localparam int CHANNELS    = 3;
    localparam int SAMPLE_W    = 8;
    localparam int PIX_W       = SAMPLE_W * CHANNELS;
    localparam int KERNEL_W    = 4;
    localparam int CHAN_W      = 2;
    localparam int SEEN_W      = 4;
    localparam int LAG_W       = 3;
    localparam int SUM_W       = 12;
    localparam int TREE_LEVELS = 4;
    localparam int TREE_LEAVES = 1 << TREE_LEVELS;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;
    // window stage, tree levels, product stage
    localparam int PIPE_TAGS   = TREE_LEVELS + 2;

    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd1;

    localparam logic [KERNEL_W-1:0] KERNEL_RESET  = 4'd3;
    localparam logic [CHAN_W-1:0]   CHANNEL_RESET = 2'd3;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef t_sample [CHANNELS-1:0] t_pixel;  // channel 0 in the lowest byte

    typedef enum logic [1:0] {
        WOP_HOLD,
        WOP_FILL,
        WOP_SHIFT
    } t_win_op;

    typedef struct packed {
        t_win_op op;
        t_pixel  data;   // fill value, or shift-in value for the head cell
    } t_win_ctrl;

    typedef struct packed {
        logic emit;
        logic done;
    } t_tag;

    typedef enum logic {
        ST_IDLE,
        ST_FLUSH
    } t_state;

    // ceil(2^16 / k); a zero kernel size acts as one
    localparam logic [RECIP_W-1:0] RECIP [TREE_LEAVES] = '{
        17'd65536, 17'd65536, 17'd32768, 17'd21846,
        17'd16384, 17'd13108, 17'd10923, 17'd9363,
        17'd8192,  17'd7282,  17'd6554,  17'd5958,
        17'd5462,  17'd5042,  17'd4682,  17'd4370
    };

endpackage

### hdl/box_filter_line_replicate_core.sv
// Top level of the line box filter: window cell chain, sequencer, sum and divide pipeline.
//
// Moving-average (box) filter along one image line, up to three 8-bit channels a pixel.
// Each output is floor(sum of K samples / K) per channel, the window centered with
// pad = K/2 and the line ends replicated; outputs trail inputs by (K-1)/2 pixels, and the
// pixel flagged with tlast flushes the pending positions, the last output of the line
// carrying tlast. Pixels enter at one per cycle. The end-of-line pixel keeps the input
// closed while the window cells replicate the last pixel and the flushed results are
// issued. The window is a chain of 15 cells, one pixel each, shifted at most once per
// cycle; the sums go through a four-level registered adder tree and a reciprocal
// multiply, so a result passes the four tree registers and the product register before
// it reaches the output register. The whole pipeline advances only while the output
// register is empty or being taken, so a stall on the output side freezes it and closes
// the input.
// kernel_size (index 0, 0 acts as 1) and channel_count (index 1, 0 acts as 1; unused
// channels read zero) are written through the plain write port; the user must write
// them only while idle; the block does not enforce it. No clearing pass after reset.
module box_filter_line_replicate_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_wr_en,
    input  logic [bfl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bfl_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input pixel stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [23:0]                       i_s_axis_tdata,  // sample_c0, sample_c1, sample_c2
    input  logic                              i_s_axis_tlast,  // end_of_line
    // filtered pixel stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [23:0]                       o_m_axis_tdata,  // avg_c0, avg_c1, avg_c2
    output logic                              o_m_axis_tlast   // line_done
);

    localparam int MK = bfl_pkg::MAX_KERNEL;

    // configuration
    logic [bfl_pkg::KERNEL_W-1:0] r_kernel;
    logic [bfl_pkg::CHAN_W-1:0]   r_chan;

    // sequencer
    bfl_pkg::t_state              r_state, n_state;
    logic [bfl_pkg::SEEN_W-1:0]   r_seen, n_seen;
    logic [bfl_pkg::LAG_W-1:0]    r_left, n_left;
    logic [bfl_pkg::LAG_W-1:0]    r_rem, n_rem;

    // pipeline tags and output register
    bfl_pkg::t_tag                r_tag [bfl_pkg::PIPE_TAGS];
    logic                         r_out_valid;
    logic                         r_out_done;
    bfl_pkg::t_pixel              r_out_data;

    logic [bfl_pkg::KERNEL_W-1:0] w_k_eff;
    logic [bfl_pkg::CHAN_W-1:0]   w_ch_eff;
    logic [bfl_pkg::LAG_W-1:0]    w_lag;
    logic [bfl_pkg::SEEN_W-1:0]   w_cnt;
    logic [bfl_pkg::LAG_W-1:0]    w_rem;
    logic                         w_adv;
    logic                         w_accept;
    bfl_pkg::t_pixel              w_in_px;
    bfl_pkg::t_win_ctrl           w_ctrl;
    bfl_pkg::t_tag                w_tag_new;

    bfl_pkg::t_pixel              w_pix  [MK];
    bfl_pkg::t_pixel              w_taps [MK];
    logic [bfl_pkg::SUM_W-1:0]    w_sums [bfl_pkg::CHANNELS];
    bfl_pkg::t_sample             w_quot [bfl_pkg::CHANNELS];

    assign w_in_px  = i_s_axis_tdata;
    assign w_k_eff  = (r_kernel == '0) ? bfl_pkg::KERNEL_W'(1) : r_kernel;
    assign w_ch_eff = (r_chan == '0) ? bfl_pkg::CHAN_W'(1) : r_chan;
    assign w_lag    = bfl_pkg::LAG_W'((w_k_eff - bfl_pkg::KERNEL_W'(1)) >> 1);
    assign w_cnt    = (r_seen == bfl_pkg::SEEN_W'(MK)) ? r_seen
                                                       : r_seen + bfl_pkg::SEEN_W'(1);
    // flushed positions: all of a line shorter than the lag, else the lag
    assign w_rem    = !i_s_axis_tlast ? '0
                    : (w_cnt < bfl_pkg::SEEN_W'(w_lag)) ? bfl_pkg::LAG_W'(w_cnt) : w_lag;

    // advance everything only when the output register can move
    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == bfl_pkg::ST_IDLE) && w_adv;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= bfl_pkg::KERNEL_RESET;
            r_chan   <= bfl_pkg::CHANNEL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                bfl_pkg::CFG_KERNEL_SIZE:   r_kernel <= i_cfg_data[bfl_pkg::KERNEL_W-1:0];
                bfl_pkg::CFG_CHANNEL_COUNT: r_chan   <= i_cfg_data[bfl_pkg::CHAN_W-1:0];
            endcase
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_seen  = r_seen;
        n_left  = r_left;
        n_rem   = r_rem;
        unique case (r_state)
            bfl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    // end of line resets the count so the next pixel fills the window
                    n_seen = i_s_axis_tlast ? '0 : w_cnt;
                    if (w_rem != '0) begin
                        n_state = bfl_pkg::ST_FLUSH;
                        n_left  = w_lag;
                        n_rem   = w_rem;
                    end
                end
            end
            bfl_pkg::ST_FLUSH: begin
                if (w_adv) begin
                    n_left = r_left - bfl_pkg::LAG_W'(1);
                    if (r_left == bfl_pkg::LAG_W'(1)) begin
                        n_state = bfl_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = bfl_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs: window operation and the tag that travels with it
    always_comb begin
        w_ctrl.op   = bfl_pkg::WOP_HOLD;
        w_ctrl.data = w_in_px;
        w_tag_new   = '0;
        unique case (r_state)
            bfl_pkg::ST_IDLE: begin
                if (w_accept) begin
                    // first pixel of a line replicates into every cell
                    w_ctrl.op      = (r_seen == '0) ? bfl_pkg::WOP_FILL : bfl_pkg::WOP_SHIFT;
                    w_tag_new.emit = w_cnt > bfl_pkg::SEEN_W'(w_lag);
                    w_tag_new.done = i_s_axis_tlast && (w_rem == '0);
                end
            end
            bfl_pkg::ST_FLUSH: begin
                if (w_adv) begin
                    // replicate the last pixel; only the final pushes produce outputs
                    w_ctrl.op      = bfl_pkg::WOP_SHIFT;
                    w_ctrl.data    = w_pix[0];
                    w_tag_new.emit = r_left <= r_rem;
                    w_tag_new.done = r_left == bfl_pkg::LAG_W'(1);
                end
            end
            default: w_ctrl.op = bfl_pkg::WOP_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bfl_pkg::ST_IDLE;
            r_seen  <= '0;
            r_left  <= '0;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_seen  <= n_seen;
            r_left  <= n_left;
            r_rem   <= n_rem;
        end
    end

    // window cell chain, newest pixel in cell 0
    for (genvar i = 0; i < MK; i++) begin : g_cell
        bfl_pkg::t_pixel w_prev;
        if (i == 0) begin : g_head
            assign w_prev = w_ctrl.data;
        end else begin : g_body
            assign w_prev = w_pix[i-1];
        end

        bfl_cell u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_prev   (w_prev),
            .i_tap_en (bfl_pkg::KERNEL_W'(i) < w_k_eff),
            .o_pixel  (w_pix[i]),
            .o_tap    (w_taps[i])
        );
    end

    bfl_sum_tree u_sum_tree (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_taps (w_taps),
        .o_sums (w_sums)
    );

    bfl_recip_div u_recip_div (
        .i_clk    (i_clk),
        .i_adv    (w_adv),
        .i_sums   (w_sums),
        .i_kernel (w_k_eff),
        .o_quot   (w_quot)
    );

    // tags follow the window operation through the tree and the multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bfl_pkg::PIPE_TAGS; i++) begin
                r_tag[i] <= '0;
            end
            r_out_valid <= 1'b0;
            r_out_done  <= 1'b0;
        end else if (w_adv) begin
            r_tag[0] <= w_tag_new;
            for (int i = 1; i < bfl_pkg::PIPE_TAGS; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
            r_out_valid <= r_tag[bfl_pkg::PIPE_TAGS-1].emit;
            r_out_done  <= r_tag[bfl_pkg::PIPE_TAGS-1].done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int c = 0; c < bfl_pkg::CHANNELS; c++) begin
                r_out_data[c] <= (bfl_pkg::CHAN_W'(c) < w_ch_eff) ? w_quot[c] : '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tlast  = r_out_done;

endmodule

### hdl/bfl_cell.sv
// One window cell: holds one pixel, loads, replicates or takes its neighbor's pixel.
module bfl_cell (
    input  logic               i_clk,
    input  bfl_pkg::t_win_ctrl i_ctrl,
    input  bfl_pkg::t_pixel    i_prev,
    input  logic               i_tap_en,
    output bfl_pkg::t_pixel    o_pixel,
    output bfl_pkg::t_pixel    o_tap
);

    bfl_pkg::t_pixel r_pixel;

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            bfl_pkg::WOP_FILL:  r_pixel <= i_ctrl.data;
            bfl_pkg::WOP_SHIFT: r_pixel <= i_prev;
            default:            r_pixel <= r_pixel;
        endcase
    end

    assign o_pixel = r_pixel;
    // drop cells beyond the active kernel from the sum
    assign o_tap   = i_tap_en ? r_pixel : '0;

endmodule

### hdl/bfl_sum_tree.sv
// Registered adder tree over the window taps, one sum per channel.
module bfl_sum_tree (
    input  logic                          i_clk,
    input  logic                          i_adv,
    input  bfl_pkg::t_pixel               i_taps [bfl_pkg::MAX_KERNEL],
    output logic [bfl_pkg::SUM_W-1:0]     o_sums [bfl_pkg::CHANNELS]
);

    localparam int L1 = bfl_pkg::TREE_LEAVES / 2;
    localparam int L2 = bfl_pkg::TREE_LEAVES / 4;
    localparam int L3 = bfl_pkg::TREE_LEAVES / 8;
    localparam int W1 = bfl_pkg::SAMPLE_W + 1;
    localparam int W2 = bfl_pkg::SAMPLE_W + 2;
    localparam int W3 = bfl_pkg::SAMPLE_W + 3;

    logic [bfl_pkg::SAMPLE_W-1:0] w_leaf [bfl_pkg::CHANNELS][bfl_pkg::TREE_LEAVES];
    logic [W1-1:0]                r_l1   [bfl_pkg::CHANNELS][L1];
    logic [W2-1:0]                r_l2   [bfl_pkg::CHANNELS][L2];
    logic [W3-1:0]                r_l3   [bfl_pkg::CHANNELS][L3];
    logic [bfl_pkg::SUM_W-1:0]    r_sum  [bfl_pkg::CHANNELS];

    always_comb begin
        for (int c = 0; c < bfl_pkg::CHANNELS; c++) begin
            for (int j = 0; j < bfl_pkg::TREE_LEAVES; j++) begin
                w_leaf[c][j] = '0;
            end
            for (int j = 0; j < bfl_pkg::MAX_KERNEL; j++) begin
                w_leaf[c][j] = i_taps[j][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int c = 0; c < bfl_pkg::CHANNELS; c++) begin
                for (int j = 0; j < L1; j++) begin
                    r_l1[c][j] <= {1'b0, w_leaf[c][2*j]} + {1'b0, w_leaf[c][2*j+1]};
                end
                for (int j = 0; j < L2; j++) begin
                    r_l2[c][j] <= {1'b0, r_l1[c][2*j]} + {1'b0, r_l1[c][2*j+1]};
                end
                for (int j = 0; j < L3; j++) begin
                    r_l3[c][j] <= {1'b0, r_l2[c][2*j]} + {1'b0, r_l2[c][2*j+1]};
                end
                r_sum[c] <= {1'b0, r_l3[c][0]} + {1'b0, r_l3[c][1]};
            end
        end
    end

    assign o_sums = r_sum;

endmodule

### hdl/bfl_recip_div.sv
// Exact division of the channel sums by the kernel size through a reciprocal multiply.
module bfl_recip_div (
    input  logic                             i_clk,
    input  logic                             i_adv,
    input  logic [bfl_pkg::SUM_W-1:0]        i_sums [bfl_pkg::CHANNELS],
    input  logic [bfl_pkg::KERNEL_W-1:0]     i_kernel,
    output bfl_pkg::t_sample                 o_quot [bfl_pkg::CHANNELS]
);

    logic [bfl_pkg::PROD_W-1:0] r_prod [bfl_pkg::CHANNELS];

    // ceil reciprocal with a 16-bit shift is exact for sums below 4096 and k up to 15
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int c = 0; c < bfl_pkg::CHANNELS; c++) begin
                r_prod[c] <= bfl_pkg::PROD_W'(i_sums[c])
                           * bfl_pkg::PROD_W'(bfl_pkg::RECIP[i_kernel]);
            end
        end
    end

    always_comb begin
        for (int c = 0; c < bfl_pkg::CHANNELS; c++) begin
            o_quot[c] = r_prod[c][bfl_pkg::RECIP_SHIFT +: bfl_pkg::SAMPLE_W];
        end
    end

endmodule

### hdl/bfl_checker.sv
// Port-level assertions for the line box filter, bound to the top level.
module bfl_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        o_s_axis_tready,
    input  logic        i_s_axis_tlast,
    input  logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [23:0] o_m_axis_tdata,
    input  logic        o_m_axis_tlast
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
        |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output beat changed while stalled");

    // no output beat right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // an output stall freezes the pipeline and closes the input
    a_stall_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input open during output stall");

    // only an end-of-line beat starts a flush that keeps the input closed
    a_mid_line_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tlast
        |=> o_s_axis_tready || (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input closed after a mid-line beat");

endmodule

bind box_filter_line_replicate_core bfl_checker u_bfl_checker (.*);

### sim/box_filter_line_replicate_core_test.sv
// Self-checking testbench for the line box filter core: directed table, then random lines.
module box_filter_line_replicate_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bfl_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 10;
    // Covers the pipeline and the longest flush, with margin. Nonemitting pixels can
    // still be in flight when the last expected beat shows up, so hold this long before
    // touching a register or ending the run.
    localparam int SETTLE_CYCLES  = 32;
    // Longest legal stretch without a beat is one settle period plus an idle burst;
    // allow many times that.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 385;
    localparam int QUIET_TAIL     = 70;

    // One filtered pixel as the output stream carries it.
    typedef struct packed {
        t_pixel avg;
        logic   line_done;
    } avg_result_t;

    typedef enum logic {
        ROW_PIXEL,
        ROW_WRITE
    } row_kind_t;

    // One directed step: a register write or a pixel, with an optional hand-typed
    // result for pixels whose single output is obvious.
    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   cfg_idx;
        logic [CFG_DATA_W-1:0]  cfg_val;
        t_pixel                 px;
        logic                   eol;
        logic                   typed;
        t_pixel                 want_avg;
        logic                   want_done;
    } stim_row_t;

    localparam int DIR_ROWS_N = 34;
    localparam stim_row_t DIR_ROWS [DIR_ROWS_N] = '{
        // reset settings (K=3, three channels): one-pixel lines give the pixel back
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'hFFFFFF, 1'b1, 1'b1, 24'hFFFFFF, 1'b1},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h000000, 1'b1, 1'b1, 24'h000000, 1'b1},
        // short line: left edge replication, then flush on the marker
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h3C5AA5, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h563412, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'hFF00FF, 1'b1, 1'b0, 24'h000000, 1'b0},
        // kernel size zero acts as one, single channel: c0 passes, c1 and c2 read zero
        '{ROW_WRITE, CFG_KERNEL_SIZE,   4'd0,  24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_WRITE, CFG_CHANNEL_COUNT, 4'd1,  24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h7EC35A, 1'b0, 1'b1, 24'h00005A, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h80FF01, 1'b1, 1'b1, 24'h000001, 1'b1},
        // largest kernel, two channels
        '{ROW_WRITE, CFG_KERNEL_SIZE,   4'd15, 24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_WRITE, CFG_CHANNEL_COUNT, 4'd2,  24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        // line shorter than the lag: everything comes out in the flush
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h102030, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'hFFFFFF, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h000000, 1'b1, 1'b0, 24'h000000, 1'b0},
        // nine pixels: the marker pixel yields its own result plus seven flushed ones
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h0F0F0F, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'hF0F0F0, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h55AA55, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'hAA55AA, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h010203, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'hFEFDFC, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h808080, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h7F7F7F, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'hC0FFEE, 1'b1, 1'b0, 24'h000000, 1'b0},
        // even kernel (zero lag), channel count zero acts as one
        '{ROW_WRITE, CFG_KERNEL_SIZE,   4'd2,  24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_WRITE, CFG_CHANNEL_COUNT, 4'd0,  24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h112233, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h445566, 1'b1, 1'b0, 24'h000000, 1'b0},
        // kernel changed in the middle of a line: window contents carry over
        '{ROW_WRITE, CFG_KERNEL_SIZE,   4'd5,  24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_WRITE, CFG_CHANNEL_COUNT, 4'd3,  24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h0A0B0C, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'hD0E0F0, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_WRITE, CFG_KERNEL_SIZE,   4'd4,  24'h000000, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h135790, 1'b0, 1'b0, 24'h000000, 1'b0},
        '{ROW_PIXEL, CFG_KERNEL_SIZE,   4'd0,  24'h2468AC, 1'b1, 1'b0, 24'h000000, 1'b0}
    };

    // DUT connections; every input is known from time zero.
    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data      = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [23:0]            i_s_axis_tdata  = '0;   // sample_c0, sample_c1, sample_c2
    logic                   i_s_axis_tlast  = 1'b0; // end_of_line
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [23:0]            o_m_axis_tdata;         // avg_c0, avg_c1, avg_c2
    logic                   o_m_axis_tlast;         // line_done

    // Predictor state: its own copy of the window and the registers.
    t_pixel                 line_window [MAX_KERNEL];
    int unsigned            line_seen   = 0;
    logic [KERNEL_W-1:0]    kernel_reg  = KERNEL_RESET;
    logic [CHAN_W-1:0]      chan_reg    = CHANNEL_RESET;

    avg_result_t            avg_expect_q [$];
    avg_result_t            rx_want;
    int                     mismatch_count = 0;
    int                     no_beat_cycles = 0;
    // Idle rates: one chance in N per beat to start a burst, zero means never.
    int                     tx_rate = 0;
    int                     rx_rate = 0;
    int                     rx_hold = 0;

    box_filter_line_replicate_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int unsigned eff_kernel();
        if (kernel_reg == 0) return 1;
        if (kernel_reg > MAX_KERNEL) return MAX_KERNEL;
        return kernel_reg;
    endfunction

    function automatic int unsigned eff_channels();
        return (chan_reg == 0) ? 1 : chan_reg;
    endfunction

    // Shift a pixel in at the head; the oldest drops off the far end.
    task automatic shift_in(input t_pixel px);
        for (int j = MAX_KERNEL - 1; j > 0; j--)
            line_window[j] = line_window[j-1];
        line_window[0] = px;
    endtask

    // Per-channel floor of the mean over the newest K pixels.
    function automatic avg_result_t window_average(input logic done);
        int unsigned k;
        int unsigned ch;
        int unsigned s;
        avg_result_t r;
        k = eff_kernel();
        ch = eff_channels();
        for (int c = 0; c < CHANNELS; c++) begin
            s = 0;
            for (int j = 0; j < k; j++)
                s += line_window[j][c];
            r.avg[c] = (c < ch) ? t_sample'(s / k) : '0;
        end
        r.line_done = done;
        return r;
    endfunction

    // Advance the predictor by one accepted pixel; queue its results when enq is set.
    task automatic predict_pixel(input t_pixel px, input logic eol, input bit enq);
        int unsigned k;
        int unsigned lag;
        int unsigned cnt;
        int unsigned rem;
        int unsigned pushes;
        avg_result_t r;
        k = eff_kernel();
        lag = k - 1 - k / 2;
        // first pixel of a line replicates across the whole window (left edge)
        if (line_seen == 0) begin
            for (int j = 0; j < MAX_KERNEL; j++)
                line_window[j] = px;
        end else begin
            shift_in(px);
        end
        cnt = (line_seen + 1 > MAX_KERNEL) ? MAX_KERNEL : line_seen + 1;
        line_seen = cnt;
        rem = eol ? ((cnt < lag) ? cnt : lag) : 0;
        if (cnt > lag) begin
            r = window_average(eol && rem == 0);
            if (enq) avg_expect_q.push_back(r);
        end
        // flush: replicate the last pixel on the right edge
        for (int unsigned t = 0; t < rem; t++) begin
            pushes = (t == 0) ? lag - rem + 1 : 1;
            repeat (pushes) shift_in(px);
            r = window_average(t + 1 == rem);
            if (enq) avg_expect_q.push_back(r);
        end
        if (eol) line_seen = 0;
    endtask

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Offer one pixel beat, maybe after an idle burst, and hold it until taken.
    task automatic send_pixel(input t_pixel px, input logic eol);
        if (tx_rate != 0 && $urandom_range(0, tx_rate - 1) == 0) begin
            repeat ($urandom_range(1, 8)) begin
                @(negedge i_clk);
                i_s_axis_tvalid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= px;
        i_s_axis_tlast  <= eol;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Drop valid, wait for every expected beat, then let in-flight pixels clear.
    task automatic drain_block();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (avg_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == CFG_KERNEL_SIZE) kernel_reg = val[KERNEL_W-1:0];
        else chan_reg = val[CHAN_W-1:0];
    endtask

    // Output-side backpressure in bursts of random length.
    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else if (rx_rate != 0 && $urandom_range(0, rx_rate - 1) == 0) begin
            rx_hold <= $urandom_range(0, 7);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // Compare every output beat with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (avg_expect_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat data %h last %b",
                                          o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                rx_want = avg_expect_q.pop_front();
                if (o_m_axis_tdata[7:0]   != rx_want.avg[0] ||
                    o_m_axis_tdata[15:8]  != rx_want.avg[1] ||
                    o_m_axis_tdata[23:16] != rx_want.avg[2] ||
                    o_m_axis_tlast        != rx_want.line_done)
                    report_mismatch($sformatf("beat data %h last %b, want data %h last %b",
                                              o_m_axis_tdata, o_m_axis_tlast,
                                              rx_want.avg, rx_want.line_done));
            end
        end
    end

    // Count cycles with no beat on either side.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            no_beat_cycles <= 0;
        else
            no_beat_cycles <= no_beat_cycles + 1;
    end

    initial begin : watchdog
        while (no_beat_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("box_filter_line_replicate_core_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : main_seq
        int                     sent;
        int                     phase;
        int                     phase_items;
        int                     taken;
        int                     line_len;
        bit                     cut;
        bit                     quiet;
        t_pixel                 px;
        logic                   eol;
        logic [CFG_DATA_W-1:0]  kv;
        logic [CHAN_W-1:0]      cv;

        sent = 0;
        phase = 0;
        quiet = 1'b0;
        for (int j = 0; j < MAX_KERNEL; j++)
            line_window[j] = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: typed rows carry their result, the rest go through the predictor.
        tx_rate = 4;
        rx_rate = 4;
        for (int i = 0; i < DIR_ROWS_N; i++) begin
            if (DIR_ROWS[i].kind == ROW_WRITE) begin
                drain_block();
                write_reg(DIR_ROWS[i].cfg_idx, DIR_ROWS[i].cfg_val);
            end else begin
                send_pixel(DIR_ROWS[i].px, DIR_ROWS[i].eol);
                predict_pixel(DIR_ROWS[i].px, DIR_ROWS[i].eol, !DIR_ROWS[i].typed);
                if (DIR_ROWS[i].typed)
                    avg_expect_q.push_back('{avg: DIR_ROWS[i].want_avg,
                                             line_done: DIR_ROWS[i].want_done});
            end
        end

        // Random phases: new settings, then whole lines of random content. Now and then
        // a line stops without its marker and the next phase resumes it under new settings.
        while (sent < RANDOM_ITEMS) begin
            drain_block();
            case (phase)
                0:       kv = 4'd15;
                1:       kv = 4'd0;
                2:       kv = 4'd1;
                default: kv = CFG_DATA_W'($urandom_range(0, 15));
            endcase
            case (phase)
                1:       cv = 2'd0;
                3:       cv = 2'd1;
                default: cv = CHAN_W'($urandom_range(0, 3));
            endcase
            write_reg(CFG_KERNEL_SIZE, kv);
            write_reg(CFG_CHANNEL_COUNT, CFG_DATA_W'(cv));

            // no idling at all in the tail of the run
            quiet = sent > RANDOM_ITEMS - QUIET_TAIL;
            case (quiet ? 0 : $urandom_range(0, 2))
                0:       tx_rate = 0;
                1:       tx_rate = 3;
                default: tx_rate = 8;
            endcase
            case (quiet ? 0 : $urandom_range(0, 2))
                0:       rx_rate = 0;
                1:       rx_rate = 3;
                default: rx_rate = 8;
            endcase

            phase_items = $urandom_range(20, 50);
            taken = 0;
            while (taken < phase_items) begin
                // mostly short lines, some past the window depth to hit saturation
                line_len = ($urandom_range(0, 7) == 0) ? $urandom_range(16, 40)
                                                       : $urandom_range(1, 12);
                cut = ($urandom_range(0, 9) == 0);
                for (int p = 0; p < line_len; p++) begin
                    px = t_pixel'($urandom());
                    if ($urandom_range(0, 15) == 0)
                        px = $urandom_range(0, 1) ? '1 : '0;
                    eol = (p == line_len - 1) && !cut;
                    send_pixel(px, eol);
                    predict_pixel(px, eol, 1'b1);
                end
                taken += line_len;
                sent += line_len;
                if (cut) break;
            end
            phase++;
        end

        drain_block();
        if (mismatch_count == 0 && avg_expect_q.size() == 0)
            $display("box_filter_line_replicate_core_test: done, clean");
        else
            $display("box_filter_line_replicate_core_test: done, errors");
        $finish;
    end

endmodule
